// ===== hdl/eadcm_pkg.sv =====
// ============================================================================
// Euler angle to DCM package
// Shared constants for the sine/cosine front end and the matrix back end.
// ============================================================================
package eadcm_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    // Taylor series terms after the first one, for both sine and cosine.
    localparam int SERIES_TERMS = 8;

    // Sine/cosine pipeline depth: three setup stages, three per term, one final.
    localparam int SC_LAT = 3 + 3 * SERIES_TERMS + 1;

    // Queue between front and back, and result queue depth.
    localparam int MID_DEPTH = 32;
    localparam int OUT_DEPTH = 8;

    // Q30 series arithmetic.
    localparam int TERM_W      = 32;
    localparam int ACC_W       = 34;
    localparam int RECIP_SHIFT = 34;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [31:0] ONE_Q30     = 32'd1073741824;

    // Divisors of the sine and cosine term recurrences.
    function automatic int sin_div(input int k);
        return (2 * k) * (2 * k + 1);
    endfunction

    function automatic int cos_div(input int k);
        return (2 * k - 1) * (2 * k);
    endfunction

endpackage

// ===== hdl/euler_angles_to_dcm.sv =====
// Path: the sine/cosine pipelines, the middle queue write and registered read, the matrix
// stages up to the result queue write, and the result output register.
// Throughput: one transaction per cycle while full is low, set by the fully pipelined
// series terms.
// Reset: rst_n asynchronously empties both queues and clears the credit counters.
// ============================================================================
// Euler angle to DCM top level
// Z-Y-X direction cosine matrix from yaw, pitch and roll binary angles.
// ============================================================================
module euler_angles_to_dcm #(
    parameter int ANGLE_BITS = eadcm_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = eadcm_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] yaw_angle,
    input  logic signed [15:0] pitch_angle,
    input  logic signed [15:0] roll_angle,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] m00,
    output logic signed [15:0] m01,
    output logic signed [15:0] m02,
    output logic signed [15:0] m10,
    output logic signed [15:0] m11,
    output logic signed [15:0] m12,
    output logic signed [15:0] m20,
    output logic signed [15:0] m21,
    output logic signed [15:0] m22
);

    localparam int W    = FRAC_BITS + 2;
    localparam int LAT  = eadcm_pkg::SC_LAT;
    localparam int MD   = eadcm_pkg::MID_DEPTH;
    localparam int OD   = eadcm_pkg::OUT_DEPTH;
    localparam int FCW  = $clog2(MD + 1);
    localparam int BCW  = $clog2(OD + 1);

    // The front end never stalls: every accepted transaction owns a slot in
    // the middle queue from acceptance until the back end reads it out.
    logic             in_take;
    logic             out_take;
    logic             mid_pop;
    logic             mid_empty;
    logic [LAT-1:0]   front_vld_reg;
    logic             mid_vld_reg;
    logic [FCW-1:0]   front_cnt_reg;
    logic [FCW-1:0]   front_cnt_next;
    logic [BCW-1:0]   back_cnt_reg;
    logic [BCW-1:0]   back_cnt_next;
    logic             back_empty;

    logic signed [W-1:0] sy, cy, sp, cp, sr, cr;
    logic [6*W-1:0]      mid_wr;
    logic [6*W-1:0]      mid_rd;

    assign full     = (front_cnt_reg == FCW'(MD));
    assign in_take  = push && !full;
    assign empty    = back_empty;
    assign out_take = pop && !back_empty;

    // The back end likewise holds a credit for each result queue slot.
    assign mid_pop  = !mid_empty && (back_cnt_reg < BCW'(OD));

    always_comb
    begin
        front_cnt_next = front_cnt_reg;
        if (in_take && !mid_pop)
        begin
            front_cnt_next = front_cnt_reg + 1'b1;
        end
        else if (!in_take && mid_pop)
        begin
            front_cnt_next = front_cnt_reg - 1'b1;
        end
    end

    always_comb
    begin
        back_cnt_next = back_cnt_reg;
        if (mid_pop && !out_take)
        begin
            back_cnt_next = back_cnt_reg + 1'b1;
        end
        else if (!mid_pop && out_take)
        begin
            back_cnt_next = back_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_vld_reg <= '0;
            mid_vld_reg   <= 1'b0;
            front_cnt_reg <= '0;
            back_cnt_reg  <= '0;
        end
        else
        begin
            front_vld_reg <= {front_vld_reg[LAT-2:0], in_take};
            mid_vld_reg   <= mid_pop;
            front_cnt_reg <= front_cnt_next;
            back_cnt_reg  <= back_cnt_next;
        end
    end

    // Front end: one sine/cosine pipeline per angle.
    eadcm_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_yaw (
        .clk     (clk),
        .angle   (yaw_angle),
        .sin_val (sy),
        .cos_val (cy)
    );

    eadcm_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_pitch (
        .clk     (clk),
        .angle   (pitch_angle),
        .sin_val (sp),
        .cos_val (cp)
    );

    eadcm_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_roll (
        .clk     (clk),
        .angle   (roll_angle),
        .sin_val (sr),
        .cos_val (cr)
    );

    assign mid_wr = {sy, cy, sp, cp, sr, cr};

    // Queue between front and back end.
    eadcm_fifo #(.WIDTH(6 * W), .DEPTH(MD)) u_mid (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_vld_reg[LAT-1]),
        .wr_data (mid_wr),
        .rd_en   (mid_pop),
        .rd_data (mid_rd),
        .empty   (mid_empty)
    );

    // Back end: products, sums, saturation and the result queue.
    eadcm_matrix #(.FRAC_BITS(FRAC_BITS), .OUT_DEPTH(OD)) u_matrix (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (mid_vld_reg),
        .sy       (mid_rd[6*W-1 -: W]),
        .cy       (mid_rd[5*W-1 -: W]),
        .sp       (mid_rd[4*W-1 -: W]),
        .cp       (mid_rd[3*W-1 -: W]),
        .sr       (mid_rd[2*W-1 -: W]),
        .cr       (mid_rd[W-1 -: W]),
        .pop      (out_take),
        .empty    (back_empty),
        .m00      (m00),
        .m01      (m01),
        .m02      (m02),
        .m10      (m10),
        .m11      (m11),
        .m12      (m12),
        .m20      (m20),
        .m21      (m21),
        .m22      (m22)
    );

endmodule

// ===== hdl/eadcm_fifo.sv =====
// ============================================================================
// Euler angle to DCM transaction queue
// Memory based queue with a registered read port, one write and one read a cycle.
// ============================================================================
module eadcm_fifo #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [AW:0]      wr_ptr_reg;
    logic [AW:0]      wr_ptr_next;
    logic [AW:0]      rd_ptr_reg;
    logic [AW:0]      rd_ptr_next;
    logic [WIDTH-1:0] rd_data_reg;

    assign wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    assign empty       = (wr_ptr_reg == rd_ptr_reg);
    assign rd_data     = rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg[AW-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_ptr_reg[AW-1:0]];
        end
    end

endmodule

// ===== hdl/eadcm_sincos.sv =====
// ============================================================================
// Euler angle to DCM sine/cosine unit
// Fully pipelined Q30 Taylor series with exact constant division per term.
// ============================================================================
module eadcm_sincos #(
    parameter int ANGLE_BITS = eadcm_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = eadcm_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic signed [15:0]          angle,
    output logic signed [FRAC_BITS+1:0] sin_val,
    output logic signed [FRAC_BITS+1:0] cos_val
);

    localparam int RW = ANGLE_BITS - 2;
    localparam int W  = FRAC_BITS + 2;
    localparam int NT = eadcm_pkg::SERIES_TERMS;
    localparam int TW = eadcm_pkg::TERM_W;
    localparam int AW = eadcm_pkg::ACC_W;
    localparam int KS = eadcm_pkg::RECIP_SHIFT;

    logic [ANGLE_BITS-1:0] phase;
    logic [RW+30:0]        prod0_reg;
    logic [1:0]            quad0_reg;
    logic [30:0]           x1_reg;
    logic [61:0]           sq1_reg;
    logic [1:0]            quad1_reg;
    logic [30:0]           x1;

    // Series state after each term; entry zero is the starting point.
    logic [TW-1:0]        ts_reg  [0:NT];
    logic [TW-1:0]        tc_reg  [0:NT];
    logic signed [AW-1:0] as_reg  [0:NT];
    logic signed [AW-1:0] ac_reg  [0:NT];
    logic [TW-1:0]        x2_reg  [0:NT];
    logic [1:0]           qd_reg  [0:NT];

    logic signed [W-1:0]  sin_reg;
    logic signed [W-1:0]  cos_reg;
    logic signed [W-1:0]  sv;
    logic signed [W-1:0]  cv;

    assign phase = ANGLE_BITS'(angle);
    assign x1    = 31'(prod0_reg >> RW);

    always_ff @(posedge clk)
    begin
        prod0_reg  <= (RW + 31)'(phase[RW-1:0]) * (RW + 31)'(eadcm_pkg::HALF_PI_Q30);
        quad0_reg  <= phase[ANGLE_BITS-1 -: 2];
        x1_reg     <= x1;
        sq1_reg    <= 62'(x1) * 62'(x1);
        quad1_reg  <= quad0_reg;
        ts_reg[0]  <= TW'(x1_reg);
        tc_reg[0]  <= eadcm_pkg::ONE_Q30;
        as_reg[0]  <= AW'(x1_reg);
        ac_reg[0]  <= AW'(eadcm_pkg::ONE_Q30);
        x2_reg[0]  <= TW'(sq1_reg >> 30);
        qd_reg[0]  <= quad1_reg;
    end

    for (genvar k = 1; k <= NT; k++)
    begin : g_term
        localparam int          DS = eadcm_pkg::sin_div(k);
        localparam int          DC = eadcm_pkg::cos_div(k);
        localparam logic [33:0] MS = 34'((64'd1 << KS) / DS);
        localparam logic [33:0] MC = 34'((64'd1 << KS) / DC);

        logic [63:0]          pa_s_reg;
        logic [63:0]          pa_c_reg;
        logic [TW-1:0]        a_x2_reg;
        logic signed [AW-1:0] a_as_reg;
        logic signed [AW-1:0] a_ac_reg;
        logic [1:0]           a_qd_reg;
        logic [33:0]          vb_s_reg;
        logic [33:0]          vb_c_reg;
        logic [67:0]          mb_s_reg;
        logic [67:0]          mb_c_reg;
        logic [TW-1:0]        b_x2_reg;
        logic signed [AW-1:0] b_as_reg;
        logic signed [AW-1:0] b_ac_reg;
        logic [1:0]           b_qd_reg;
        logic [33:0]          vs;
        logic [33:0]          vc;
        logic [31:0]          q0s;
        logic [31:0]          q0c;
        logic [33:0]          rs;
        logic [33:0]          rc;
        logic [31:0]          qs;
        logic [31:0]          qc;

        assign vs  = 34'(pa_s_reg >> 30);
        assign vc  = 34'(pa_c_reg >> 30);
        assign q0s = 32'(mb_s_reg >> KS);
        assign q0c = 32'(mb_c_reg >> KS);
        // The reciprocal estimate is low by at most one.
        assign rs  = vb_s_reg - 34'(q0s) * 34'(DS);
        assign rc  = vb_c_reg - 34'(q0c) * 34'(DC);
        assign qs  = (rs >= 34'(DS)) ? q0s + 32'd1 : q0s;
        assign qc  = (rc >= 34'(DC)) ? q0c + 32'd1 : q0c;

        always_ff @(posedge clk)
        begin
            pa_s_reg <= 64'(ts_reg[k-1]) * 64'(x2_reg[k-1]);
            pa_c_reg <= 64'(tc_reg[k-1]) * 64'(x2_reg[k-1]);
            a_x2_reg <= x2_reg[k-1];
            a_as_reg <= as_reg[k-1];
            a_ac_reg <= ac_reg[k-1];
            a_qd_reg <= qd_reg[k-1];
            vb_s_reg <= vs;
            vb_c_reg <= vc;
            mb_s_reg <= 68'(vs) * 68'(MS);
            mb_c_reg <= 68'(vc) * 68'(MC);
            b_x2_reg <= a_x2_reg;
            b_as_reg <= a_as_reg;
            b_ac_reg <= a_ac_reg;
            b_qd_reg <= a_qd_reg;
            ts_reg[k] <= qs;
            tc_reg[k] <= qc;
            x2_reg[k] <= b_x2_reg;
            qd_reg[k] <= b_qd_reg;
            if (k % 2 == 1)
            begin
                as_reg[k] <= b_as_reg - AW'(qs);
                ac_reg[k] <= b_ac_reg - AW'(qc);
            end
            else
            begin
                as_reg[k] <= b_as_reg + AW'(qs);
                ac_reg[k] <= b_ac_reg + AW'(qc);
            end
        end
    end

    // Clamp at zero, round half up to the output fraction and clamp at one.
    function automatic logic signed [W-1:0] to_frac(input logic signed [AW-1:0] v);
        logic [AW-1:0] u;
        logic [W-1:0]  r;
        u = (AW'(v) + (AW'(1) << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        if (v[AW-1])
        begin
            r = '0;
        end
        else if (u > (AW'(1) << FRAC_BITS))
        begin
            r = W'(1) << FRAC_BITS;
        end
        else
        begin
            r = W'(u);
        end
        return signed'(r);
    endfunction

    assign sv = to_frac(as_reg[NT]);
    assign cv = to_frac(ac_reg[NT]);

    always_ff @(posedge clk)
    begin
        unique case (qd_reg[NT])
            2'd0:
            begin
                sin_reg <= sv;
                cos_reg <= cv;
            end
            2'd1:
            begin
                sin_reg <= cv;
                cos_reg <= -sv;
            end
            2'd2:
            begin
                sin_reg <= -sv;
                cos_reg <= -cv;
            end
            default:
            begin
                sin_reg <= -cv;
                cos_reg <= sv;
            end
        endcase
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

// ===== hdl/eadcm_matrix.sv =====
// ============================================================================
// Euler angle to DCM matrix back end
// Three stage product and sum pipeline feeding a small result queue.
// ============================================================================
module eadcm_matrix #(
    parameter int FRAC_BITS = eadcm_pkg::FRAC_BITS_DEF,
    parameter int OUT_DEPTH = eadcm_pkg::OUT_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic signed [FRAC_BITS+1:0] sy,
    input  logic signed [FRAC_BITS+1:0] cy,
    input  logic signed [FRAC_BITS+1:0] sp,
    input  logic signed [FRAC_BITS+1:0] cp,
    input  logic signed [FRAC_BITS+1:0] sr,
    input  logic signed [FRAC_BITS+1:0] cr,
    input  logic                        pop,
    output logic                        empty,
    output logic signed [15:0]          m00,
    output logic signed [15:0]          m01,
    output logic signed [15:0]          m02,
    output logic signed [15:0]          m10,
    output logic signed [15:0]          m11,
    output logic signed [15:0]          m12,
    output logic signed [15:0]          m20,
    output logic signed [15:0]          m21,
    output logic signed [15:0]          m22
);

    localparam int W  = FRAC_BITS + 2;
    localparam int PW = 2 * W;
    localparam int QA = $clog2(OUT_DEPTH);

    typedef logic [8:0][15:0] dcm_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [W-1:0] val_t;

    function automatic val_t rnd(input prod_t p);
        prod_t t;
        t = p + (PW'(1) <<< (FRAC_BITS - 1));
        return W'(t >>> FRAC_BITS);
    endfunction

    function automatic logic [15:0] sat(input logic signed [W:0] v);
        logic signed [W:0] one;
        logic signed [W:0] r;
        one = (W + 1)'(1) <<< FRAC_BITS;
        if (v > one)
        begin
            r = one;
        end
        else if (v < -one)
        begin
            r = -one;
        end
        else
        begin
            r = v;
        end
        return 16'(r);
    endfunction

    logic  [1:0] vld_reg;
    prod_t p_srsp_reg, p_crsp_reg, p_cpcy_reg, p_cpsy_reg, p_sycr_reg;
    prod_t p_cycr_reg, p_srcp_reg, p_srsy_reg, p_srcy_reg, p_crcp_reg;
    val_t  s1_sy_reg, s1_cy_reg, s1_sp_reg;
    prod_t q_a_reg, q_b_reg, q_c_reg, q_d_reg;
    val_t  r_cpcy_reg, r_cpsy_reg, r_sycr_reg, r_cycr_reg, r_srcp_reg;
    val_t  r_srsy_reg, r_srcy_reg, r_crcp_reg, s2_sp_reg;
    val_t  srsp;
    val_t  crsp;
    dcm_t  row;

    dcm_t        q_mem [0:OUT_DEPTH-1];
    dcm_t        out_reg;
    logic        out_vld_reg;
    logic        out_vld_next;
    logic [QA:0] wr_ptr_reg;
    logic [QA:0] wr_ptr_next;
    logic [QA:0] rd_ptr_reg;
    logic [QA:0] rd_ptr_next;
    logic        mem_empty;
    logic        out_load;
    logic        out_take;

    assign srsp = rnd(p_srsp_reg);
    assign crsp = rnd(p_crsp_reg);

    always_ff @(posedge clk)
    begin
        p_srsp_reg <= PW'(sr) * PW'(sp);
        p_crsp_reg <= PW'(cr) * PW'(sp);
        p_cpcy_reg <= PW'(cp) * PW'(cy);
        p_cpsy_reg <= PW'(cp) * PW'(sy);
        p_sycr_reg <= PW'(sy) * PW'(cr);
        p_cycr_reg <= PW'(cy) * PW'(cr);
        p_srcp_reg <= PW'(sr) * PW'(cp);
        p_srsy_reg <= PW'(sr) * PW'(sy);
        p_srcy_reg <= PW'(sr) * PW'(cy);
        p_crcp_reg <= PW'(cr) * PW'(cp);
        s1_sy_reg  <= sy;
        s1_cy_reg  <= cy;
        s1_sp_reg  <= sp;

        q_a_reg    <= PW'(srsp) * PW'(s1_cy_reg);
        q_b_reg    <= PW'(srsp) * PW'(s1_sy_reg);
        q_c_reg    <= PW'(crsp) * PW'(s1_cy_reg);
        q_d_reg    <= PW'(crsp) * PW'(s1_sy_reg);
        r_cpcy_reg <= rnd(p_cpcy_reg);
        r_cpsy_reg <= rnd(p_cpsy_reg);
        r_sycr_reg <= rnd(p_sycr_reg);
        r_cycr_reg <= rnd(p_cycr_reg);
        r_srcp_reg <= rnd(p_srcp_reg);
        r_srsy_reg <= rnd(p_srsy_reg);
        r_srcy_reg <= rnd(p_srcy_reg);
        r_crcp_reg <= rnd(p_crcp_reg);
        s2_sp_reg  <= s1_sp_reg;
    end

    always_comb
    begin
        row[0] = sat((W + 1)'(r_cpcy_reg));
        row[1] = sat((W + 1)'(r_cpsy_reg));
        row[2] = sat(-(W + 1)'(s2_sp_reg));
        row[3] = sat((W + 1)'(rnd(q_a_reg)) - (W + 1)'(r_sycr_reg));
        row[4] = sat((W + 1)'(rnd(q_b_reg)) + (W + 1)'(r_cycr_reg));
        row[5] = sat((W + 1)'(r_srcp_reg));
        row[6] = sat((W + 1)'(rnd(q_c_reg)) + (W + 1)'(r_srsy_reg));
        row[7] = sat((W + 1)'(rnd(q_d_reg)) - (W + 1)'(r_srcy_reg));
        row[8] = sat((W + 1)'(r_crcp_reg));
    end

    // The output register shows the oldest result; it refills from a
    // non-empty memory whenever it is empty or being popped.
    assign mem_empty    = (wr_ptr_reg == rd_ptr_reg);
    assign empty        = !out_vld_reg;
    assign out_take     = pop && out_vld_reg;
    assign out_load     = !mem_empty && (!out_vld_reg || out_take);
    assign out_vld_next = out_load || (out_vld_reg && !out_take);
    assign wr_ptr_next  = vld_reg[1] ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next  = out_load ? rd_ptr_reg + 1'b1 : rd_ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg     <= {vld_reg[0], in_valid};
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // The sum stage writes straight into the result queue.
    always_ff @(posedge clk)
    begin
        if (vld_reg[1])
        begin
            q_mem[wr_ptr_reg[QA-1:0]] <= row;
        end
        if (out_load)
        begin
            out_reg <= q_mem[rd_ptr_reg[QA-1:0]];
        end
    end

    assign m00 = out_reg[0];
    assign m01 = out_reg[1];
    assign m02 = out_reg[2];
    assign m10 = out_reg[3];
    assign m11 = out_reg[4];
    assign m12 = out_reg[5];
    assign m20 = out_reg[6];
    assign m21 = out_reg[7];
    assign m22 = out_reg[8];

endmodule
